// ===== rtl/wnc_pkg.sv =====
// Package for the weighted nearest-colour tile matcher.
// Sizes, field layouts, opcodes and status codes; no dependencies.
package wnc_pkg;

   localparam int TILE_SLOTS     = 256;
   localparam int USE_COUNT_BITS = 16;

   localparam int SLOT_BITS       = $clog2(TILE_SLOTS);
   localparam int CNT_BITS        = SLOT_BITS + 1;
   localparam int CFG_BITS        = 9;
   localparam int CLAMP_BITS      = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int SLOT_FIELD_BITS = 8;
   localparam int SLOT_CMP_BITS   =
      ((SLOT_BITS > SLOT_FIELD_BITS) ? SLOT_BITS : SLOT_FIELD_BITS) + 1;
   localparam int CHAN_BITS       = 16;
   localparam int SUM_BITS        = CHAN_BITS + 2;
   localparam int PROD_BITS       = USE_COUNT_BITS + SUM_BITS;
   localparam int FRAC_BITS       = 8;
   localparam int SCORE_BITS      = 32;
   localparam int SHIFTED_BITS    = PROD_BITS - FRAC_BITS;
   localparam int SAT_BITS        =
      (SHIFTED_BITS > SCORE_BITS) ? SHIFTED_BITS : SCORE_BITS + 1;
   localparam int SHIFT_BITS      = CHAN_BITS + 1;
   localparam int STATUS_BITS     = 2;
   localparam int REQ_DATA_BITS   = 56;
   localparam int RSP_DATA_BITS   = 96;
   localparam int RSP_PAD_BITS    =
      RSP_DATA_BITS - SLOT_FIELD_BITS - SCORE_BITS - 3 * SHIFT_BITS;

   localparam logic [USE_COUNT_BITS-1:0] USE_MAX   = '1;
   localparam logic [SCORE_BITS-1:0]     SCORE_MAX = '1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   localparam logic [STATUS_BITS-1:0] STAT_MATCH = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_LOAD  = 2'd2;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } color_type;

   typedef struct packed {
      logic [USE_COUNT_BITS-1:0] uses;
      color_type                 color;
   } entry_type;

   // scored candidate leaving the score pipe
   typedef struct packed {
      logic                  vld;
      logic                  busy;
      logic [SLOT_BITS-1:0]  slot;
      entry_type             entry;
      logic [SCORE_BITS-1:0] score;
   } cand_type;

   typedef struct packed {
      logic [SLOT_FIELD_BITS-1:0]   best_slot;
      logic [SCORE_BITS-1:0]        best_score;
      logic signed [SHIFT_BITS-1:0] red_shift;
      logic signed [SHIFT_BITS-1:0] green_shift;
      logic signed [SHIFT_BITS-1:0] blue_shift;
      logic [STATUS_BITS-1:0]       status;
   } result_type;

endpackage

// ===== rtl/wnc_score_pipe.sv =====
// Two-stage scoring pipe: L1 colour distance, then use-count weighting
// with integer truncation and saturation. Uses wnc_pkg.
module wnc_score_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic [wnc_pkg::SLOT_BITS-1:0] in_slot,
   input  wnc_pkg::entry_type            in_entry,
   input  wnc_pkg::color_type            region,
   output wnc_pkg::cand_type             cand
);

   logic                                s2_vld_ff;
   logic [wnc_pkg::SLOT_BITS-1:0]       s2_slot_ff;
   wnc_pkg::entry_type                  s2_entry_ff;
   logic [wnc_pkg::SUM_BITS-1:0]        s2_sum_ff;
   logic [wnc_pkg::SUM_BITS-1:0]        s2_sum_in;

   logic                                s3_vld_ff;
   logic [wnc_pkg::SLOT_BITS-1:0]       s3_slot_ff;
   wnc_pkg::entry_type                  s3_entry_ff;
   logic [wnc_pkg::PROD_BITS-1:0]       s3_prod_ff;
   logic [wnc_pkg::PROD_BITS-1:0]       s3_prod_in;

   logic [wnc_pkg::CHAN_BITS-1:0]       d_red, d_green, d_blue;
   logic [wnc_pkg::SAT_BITS-1:0]        shifted;

   function automatic logic [wnc_pkg::CHAN_BITS-1:0] abs_diff(
      input logic [wnc_pkg::CHAN_BITS-1:0] a,
      input logic [wnc_pkg::CHAN_BITS-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   always_comb begin
      d_red     = abs_diff(region.red,   in_entry.color.red);
      d_green   = abs_diff(region.green, in_entry.color.green);
      d_blue    = abs_diff(region.blue,  in_entry.color.blue);
      s2_sum_in = wnc_pkg::SUM_BITS'(d_red) + wnc_pkg::SUM_BITS'(d_green)
                + wnc_pkg::SUM_BITS'(d_blue);
      s3_prod_in = wnc_pkg::PROD_BITS'(s2_entry_ff.uses)
                 * wnc_pkg::PROD_BITS'(s2_sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= in_vld;
         s3_vld_ff <= s2_vld_ff;
      end
      s2_slot_ff  <= in_slot;
      s2_entry_ff <= in_entry;
      s2_sum_ff   <= s2_sum_in;
      s3_slot_ff  <= s2_slot_ff;
      s3_entry_ff <= s2_entry_ff;
      s3_prod_ff  <= s3_prod_in;
   end

   always_comb begin
      shifted    = wnc_pkg::SAT_BITS'(s3_prod_ff[wnc_pkg::PROD_BITS-1:wnc_pkg::FRAC_BITS]);
      cand.vld   = s3_vld_ff;
      cand.busy  = s2_vld_ff | s3_vld_ff;
      cand.slot  = s3_slot_ff;
      cand.entry = s3_entry_ff;
      if (shifted > wnc_pkg::SAT_BITS'(wnc_pkg::SCORE_MAX)) begin
         cand.score = wnc_pkg::SCORE_MAX;
      end else begin
         cand.score = shifted[wnc_pkg::SCORE_BITS-1:0];
      end
   end

endmodule

// ===== rtl/weighted_nearest_color_tile_match_top.sv =====
// Top level of the weighted nearest-colour tile matcher: tile table memory,
// scan sequencer, best-candidate tracking and output register.
// Uses wnc_pkg and wnc_score_pipe.

// A load item writes one tile entry and answers through the response state. A
// match item reads the tile memory through one read port, one entry a cycle, then
// drains the read and scoring pipe, writes back the use count of the best tile
// and hands over the result. A match while tiles_in_use is zero answers with the
// empty status and does no scan. After reset a clearing pass over all TILE_SLOTS
// (256) slots sets every use count to 1 before the first item is taken; csr
// writes are taken at once.
module weighted_nearest_color_tile_match_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wnc_pkg::CFG_BITS-1:0]      csr_data,      // tiles_in_use
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tile_slot[7:0], red_mean[23:8], green_mean[39:24], blue_mean[55:40]
   input  logic [wnc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tuser,     // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // best_slot[7:0], best_score[39:8], red_shift[56:40], green_shift[73:57],
   // blue_shift[90:74], zero pad
   output logic [wnc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [wnc_pkg::STATUS_BITS-1:0]   rsp_tuser      // status
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_WBACK = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [wnc_pkg::CFG_BITS-1:0]       tiles_ff;
   logic [wnc_pkg::SLOT_BITS-1:0]      clr_ff;
   logic [wnc_pkg::CNT_BITS-1:0]       count_ff;
   logic [wnc_pkg::CNT_BITS-1:0]       rd_ptr_ff;
   wnc_pkg::color_type                 region_ff;
   logic                               have_ff;
   logic [wnc_pkg::SLOT_BITS-1:0]      best_slot_ff;
   wnc_pkg::entry_type                 best_entry_ff;
   logic [wnc_pkg::SCORE_BITS-1:0]     best_score_ff;
   wnc_pkg::result_type                res_ff, res_in;
   wnc_pkg::result_type                out_ff;
   logic                               out_vld_ff;

   wnc_pkg::entry_type                 mem [wnc_pkg::TILE_SLOTS];
   wnc_pkg::entry_type                 mem_q_ff;
   logic                               s1_vld_ff;
   logic [wnc_pkg::SLOT_BITS-1:0]      s1_slot_ff;

   logic                               req_acc;
   logic                               rd_en;
   logic                               wr_en;
   logic [wnc_pkg::SLOT_BITS-1:0]      wr_addr;
   wnc_pkg::entry_type                 wr_data;

   logic [wnc_pkg::SLOT_FIELD_BITS-1:0] req_slot;
   wnc_pkg::color_type                 req_color;
   logic                               load_ok;
   logic [wnc_pkg::CNT_BITS-1:0]       count_clamped;
   logic [wnc_pkg::USE_COUNT_BITS-1:0] uses_next;
   logic                               out_free;
   logic                               better;
   wnc_pkg::cand_type                  cand;

   assign req_slot        = req_tdata[7:0];
   assign req_color.red   = req_tdata[23:8];
   assign req_color.green = req_tdata[39:24];
   assign req_color.blue  = req_tdata[55:40];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign out_free   = ~out_vld_ff | rsp_tready;

   assign load_ok = wnc_pkg::SLOT_CMP_BITS'(req_slot)
                  < wnc_pkg::SLOT_CMP_BITS'(wnc_pkg::TILE_SLOTS);

   always_comb begin
      if (wnc_pkg::CLAMP_BITS'(tiles_ff) > wnc_pkg::CLAMP_BITS'(wnc_pkg::TILE_SLOTS)) begin
         count_clamped = wnc_pkg::CNT_BITS'(wnc_pkg::TILE_SLOTS);
      end else begin
         count_clamped = wnc_pkg::CNT_BITS'(tiles_ff);
      end
   end

   assign rd_en  = (state_ff == ST_SCAN) && (rd_ptr_ff < count_ff);
   assign better = cand.vld && (!have_ff || cand.score < best_score_ff);
   assign uses_next = (best_entry_ff.uses == wnc_pkg::USE_MAX) ?
                      best_entry_ff.uses : best_entry_ff.uses + 1'b1;

   // memory write port: clearing pass, tile load, use-count write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '{uses: wnc_pkg::USE_COUNT_BITS'(1), color: '0};
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            wr_en   = req_acc && (req_tuser == wnc_pkg::OP_LOAD) && load_ok;
            wr_addr = wnc_pkg::SLOT_BITS'(req_slot);
            wr_data = '{uses: wnc_pkg::USE_COUNT_BITS'(1), color: req_color};
         end
         ST_WBACK: begin
            wr_en   = 1'b1;
            wr_addr = best_slot_ff;
            wr_data = '{uses: uses_next, color: best_entry_ff.color};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_ptr_ff[wnc_pkg::SLOT_BITS-1:0]];
      end
      s1_slot_ff <= rd_ptr_ff[wnc_pkg::SLOT_BITS-1:0];
   end

   wnc_score_pipe u_score (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s1_vld_ff),
      .in_slot  (s1_slot_ff),
      .in_entry (mem_q_ff),
      .region   (region_ff),
      .cand     (cand)
   );

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == wnc_pkg::SLOT_BITS'(wnc_pkg::TILE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               res_in = '0;
               if (req_tuser == wnc_pkg::OP_LOAD) begin
                  res_in.status = wnc_pkg::STAT_LOAD;
                  state_in      = ST_RESP;
               end else if (count_clamped == '0) begin
                  res_in.status = wnc_pkg::STAT_EMPTY;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_ptr_ff == count_ff && !s1_vld_ff && !cand.busy) begin
               state_in = ST_WBACK;
            end
         end
         ST_WBACK: begin
            res_in.best_slot   = wnc_pkg::SLOT_FIELD_BITS'(best_slot_ff);
            res_in.best_score  = best_score_ff;
            res_in.red_shift   = {1'b0, region_ff.red} - {1'b0, best_entry_ff.color.red};
            res_in.green_shift = {1'b0, region_ff.green}
                               - {1'b0, best_entry_ff.color.green};
            res_in.blue_shift  = {1'b0, region_ff.blue} - {1'b0, best_entry_ff.color.blue};
            res_in.status      = wnc_pkg::STAT_MATCH;
            state_in           = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         tiles_ff   <= '0;
         clr_ff     <= '0;
         rd_ptr_ff  <= '0;
         have_ff    <= 1'b0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= rd_en;
         if (csr_valid && csr_ready) begin
            tiles_ff <= csr_data;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (req_acc) begin
            rd_ptr_ff <= '0;
            have_ff   <= 1'b0;
         end else begin
            if (rd_en) begin
               rd_ptr_ff <= rd_ptr_ff + 1'b1;
            end
            if (better) begin
               have_ff <= 1'b1;
            end
         end
         if (state_ff == ST_RESP && out_free) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (req_acc) begin
         region_ff <= req_color;
         count_ff  <= count_clamped;
      end
      if (better) begin
         best_slot_ff  <= cand.slot;
         best_entry_ff <= cand.entry;
         best_score_ff <= cand.score;
      end
      if (state_ff == ST_RESP && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {{wnc_pkg::RSP_PAD_BITS{1'b0}}, out_ff.blue_shift,
                        out_ff.green_shift, out_ff.red_shift,
                        out_ff.best_score, out_ff.best_slot};

endmodule
